[sv/mlpbp_pkg.sv]
// shared types, constants and fixed-point helpers of the two-layer perceptron trainer
// no dependencies; used by mlpbp_cell, mlpbp_sigmoid_rom and mlp_backprop_trainer
`default_nettype none

package mlpbp_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_INFER = 2'd1;
  localparam logic [1:0] ACT_TRAIN = 2'd2;
  localparam logic [1:0] ACT_APPLY = 2'd3;

  localparam logic [15:0] RATE_RESET = 16'd6554;

  // e^-k in Q32 for k = 0..8
  localparam logic [63:0] EXP_NEG_INT [9] = '{
    64'd4294967296, 64'd1580030169, 64'd581260615, 64'd213833830, 64'd78665039,
    64'd28939263, 64'd10646160, 64'd3916503, 64'd1440801
  };

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [15:0] val;
  } wcmd_t;

  // shift right, rounding half toward plus infinity
  function automatic logic signed [63:0] rnd_sh(logic signed [63:0] v, int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic ovf16(logic signed [63:0] v);
    return (v > 64'sd32767) || (v < -64'sd32768);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic ovf32(logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // unsigned quotient by restoring shift and subtract, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid at a Q32 point pos (0..2^36 spans -8..8), Q12 result, elaboration only
  function automatic logic [12:0] sig_value(logic [63:0] pos);
    logic [63:0] mid;
    logic        neg;
    logic [63:0] a;
    logic [63:0] k;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] ef;
    logic [63:0] inv;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    mid  = 64'd1 << 35;
    neg  = pos < mid;
    a    = neg ? mid - pos : pos - mid;
    k    = a >> 32;
    f    = a & 64'hffff_ffff;
    term = 64'd1 << 32;
    ef   = term;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64((term * f) >> 32, 64'(n));
      ef   = ef + term;
    end
    inv = udiv64(64'hffff_ffff_ffff_ffff, ef);
    if (k > 64'd8) k = 64'd8;
    e   = (EXP_NEG_INT[k[3:0]] * inv) >> 32;
    den = (64'd1 << 32) + e;
    s   = udiv64((64'd1 << 44) + (den >> 1), den);
    return neg ? 13'(64'd4096 - s) : s[12:0];
  endfunction

endpackage

`default_nettype wire

[sv/mlp_backprop_trainer.sv]
// two-layer perceptron trainer: sequencer with shared arithmetic over a ring of neuron cells
// depends on mlpbp_pkg, mlpbp_cell, mlpbp_sigmoid_rom
//
//  channel | dir | handshake              | payload
//  in      | in  | in_tvalid / in_tready  | tdata: 5 fields, tuser: action
//  out     | out | out_tvalid / out_tready | tdata: prediction, output_error; tuser: saturated
//  cfg     | in  | cfg_valid / cfg_ready  | learn_rate
//
// infer, train and apply run on the single arithmetic path, which visits each neuron cell in turn
// as the ring rotates past it.
// one item in work at a time; a new word is taken while a result waits at the output.
// rst_n clears weights, change sums and learn_rate to their reset values.
`default_nettype none

module mlp_backprop_trainer #(
  parameter int NUM_INPUTS      = 2,
  parameter int NUM_HIDDEN      = 8,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // feature_a, feature_b, target, weight_index, weight_value, zero pad
  input  wire logic [71:0] in_tdata,
  // action
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // prediction, output_error
  output logic      [31:0] out_tdata,
  // saturated
  output logic      [0:0]  out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int NI  = NUM_INPUTS;
  localparam int NH  = NUM_HIDDEN;
  localparam int JW  = (NI > 1) ? $clog2(NI) : 1;
  localparam int NW  = (NH > 1) ? $clog2(NH) : 1;
  localparam int IW  = $clog2(SIGMOID_ENTRIES);
  localparam int HWW = NI * 16;
  localparam int HCW = NI * 32;

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_APPLY = 16'b0000_0000_0000_0010,
    S_FMUL  = 16'b0000_0000_0000_0100,
    S_FACT  = 16'b0000_0000_0000_1000,
    S_FDY   = 16'b0000_0000_0001_0000,
    S_FOUT  = 16'b0000_0000_0010_0000,
    S_PRED  = 16'b0000_0000_0100_0000,
    S_BOY   = 16'b0000_0000_1000_0000,
    S_BOC   = 16'b0000_0001_0000_0000,
    S_BEO   = 16'b0000_0010_0000_0000,
    S_BHD   = 16'b0000_0100_0000_0000,
    S_BHM   = 16'b0000_1000_0000_0000,
    S_BHA   = 16'b0001_0000_0000_0000,
    S_DONE  = 16'b0010_0000_0000_0000
  } state_t;

  state_t state_r;
  logic [15:0] rate_r;
  logic        train_r;
  logic signed [15:0] x_r [NI];
  logic signed [15:0] tgt_r;
  logic [JW-1:0] j_r;
  logic [NW-1:0] n_r;
  logic signed [39:0] acc_r;
  logic signed [39:0] oacc_r;
  logic [12:0] y_r;
  logic [10:0] dy_r;
  logic signed [15:0] pred_r;
  logic signed [15:0] err_r;
  logic        sat_r;
  logic signed [31:0] t_r;
  logic signed [31:0] ocn_r;
  logic signed [19:0] hd_r;
  logic signed [35:0] p_r;
  logic [HCW-1:0] hcn_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_sat_r;

  // ring: index k is cell k's output, the tail cell is fed from tl_*
  logic [HWW-1:0] c_hw [NH];
  logic [15:0]    c_ow [NH];
  logic [HCW-1:0] c_hc [NH];
  logic [31:0]    c_oc [NH];
  logic [12:0]    c_y  [NH];
  logic [10:0]    c_dy [NH];

  logic [HWW-1:0] tl_hw;
  logic [15:0]    tl_ow;
  logic [HCW-1:0] tl_hc;
  logic [31:0]    tl_oc;
  logic [12:0]    tl_y;
  logic [10:0]    tl_dy;

  logic shift;
  mlpbp_pkg::wcmd_t wr_cmd;
  logic in_acc;
  logic [12:0] rom_y;
  logic [IW-1:0] rom_idx;

  // combinational results
  logic signed [15:0] hw_j;
  logic signed [15:0] x_j;
  logic signed [31:0] hc_j;
  logic signed [39:0] fmul_sum;
  logic signed [15:0] h16;
  logic        h_ovf;
  logic [31:0] idx_prod;
  logic [10:0] dy_val;
  logic signed [39:0] oacc_sum;
  logic signed [63:0] psum;
  logic signed [15:0] pred_v;
  logic        pred_ovf;
  logic signed [63:0] err_raw;
  logic signed [15:0] err_v;
  logic        err_ovf;
  logic signed [63:0] oc_sum;
  logic signed [63:0] hc_sum;
  logic        ap_ovf;
  logic signed [63:0] ap_tmp;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign wr_cmd.en  = in_acc && (in_tuser == mlpbp_pkg::ACT_WRITE);
  assign wr_cmd.idx = in_tdata[52:48];
  assign wr_cmd.val = in_tdata[68:53];

  for (genvar k = 0; k < NH; k++) begin : g_cell
    localparam bit TAIL = (k == NH - 1);
    localparam int NXT  = TAIL ? 0 : k + 1;
    mlpbp_cell #(
      .NUM_INPUTS(NI),
      .NUM_HIDDEN(NH),
      .CELL_ID(k)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .shift(shift),
      .wr   (wr_cmd),
      .hw_i (TAIL ? tl_hw : c_hw[NXT]),
      .ow_i (TAIL ? tl_ow : c_ow[NXT]),
      .hc_i (TAIL ? tl_hc : c_hc[NXT]),
      .oc_i (TAIL ? tl_oc : c_oc[NXT]),
      .y_i  (TAIL ? tl_y  : c_y[NXT]),
      .dy_i (TAIL ? tl_dy : c_dy[NXT]),
      .hw_o (c_hw[k]),
      .ow_o (c_ow[k]),
      .hc_o (c_hc[k]),
      .oc_o (c_oc[k]),
      .y_o  (c_y[k]),
      .dy_o (c_dy[k])
    );
  end

  mlpbp_sigmoid_rom #(
    .ENTRIES(SIGMOID_ENTRIES)
  ) u_rom (
    .clk(clk),
    .en (state_r == S_FACT),
    .idx(rom_idx),
    .y  (rom_y)
  );

  always_comb begin
    hw_j = c_hw[0][j_r*16 +: 16];
    x_j  = x_r[j_r];
    hc_j = c_hc[0][j_r*32 +: 32];

    fmul_sum = acc_r + 40'(hw_j) * 40'(x_j);

    h16      = mlpbp_pkg::sat16(mlpbp_pkg::rnd_sh(64'(acc_r), 12));
    h_ovf    = mlpbp_pkg::ovf16(mlpbp_pkg::rnd_sh(64'(acc_r), 12));
    // offset binary of the hidden sum scaled onto the table
    idx_prod = 32'(h16 ^ 16'sh8000) * 32'(SIGMOID_ENTRIES);
    rom_idx  = idx_prod[16 +: IW];

    dy_val = 11'(((26'(rom_y) * 26'(13'd4096 - rom_y)) + 26'd2048) >> 12);

    oacc_sum = oacc_r + 40'($signed(c_ow[0])) * 40'($signed({1'b0, y_r}));

    psum     = mlpbp_pkg::rnd_sh(64'(oacc_r), 12);
    pred_v   = mlpbp_pkg::sat16(psum);
    pred_ovf = mlpbp_pkg::ovf16(psum);
    err_raw  = 64'(tgt_r) - 64'(pred_v);
    err_v    = mlpbp_pkg::sat16(err_raw);
    err_ovf  = mlpbp_pkg::ovf16(err_raw);

    oc_sum = 64'($signed(c_oc[0]))
           + mlpbp_pkg::rnd_sh($signed(64'(rate_r)) * 64'(t_r), 16);
    hc_sum = 64'(hc_j)
           + mlpbp_pkg::rnd_sh($signed(64'(rate_r)) * 64'(p_r), 16);

    // tail feed defaults to the head contents
    tl_hw  = c_hw[0];
    tl_ow  = c_ow[0];
    tl_hc  = c_hc[0];
    tl_oc  = c_oc[0];
    tl_y   = c_y[0];
    tl_dy  = c_dy[0];
    shift  = 1'b0;
    ap_ovf = 1'b0;
    ap_tmp = '0;

    case (state_r)
      S_APPLY: begin
        shift = 1'b1;
        for (int j = 0; j < NI; j++) begin
          ap_tmp = 64'($signed(c_hw[0][j*16 +: 16]))
                 + mlpbp_pkg::rnd_sh(64'($signed(c_hc[0][j*32 +: 32])), 12);
          tl_hw[j*16 +: 16] = mlpbp_pkg::sat16(ap_tmp);
          ap_ovf = ap_ovf | mlpbp_pkg::ovf16(ap_tmp);
        end
        ap_tmp = 64'($signed(c_ow[0])) + mlpbp_pkg::rnd_sh(64'($signed(c_oc[0])), 12);
        tl_ow  = mlpbp_pkg::sat16(ap_tmp);
        ap_ovf = ap_ovf | mlpbp_pkg::ovf16(ap_tmp);
        tl_hc  = '0;
        tl_oc  = '0;
      end
      S_FOUT: begin
        shift = 1'b1;
        tl_y  = y_r;
        tl_dy = dy_r;
      end
      S_BHA: begin
        if (j_r == JW'(NI - 1)) begin
          shift = 1'b1;
          tl_oc = ocn_r;
          tl_hc = hcn_r;
          tl_hc[j_r*32 +: 32] = mlpbp_pkg::sat32(hc_sum);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= mlpbp_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            for (int j = 0; j < NI; j++) begin
              if (j == 0) begin
                x_r[j] <= in_tdata[15:0];
              end else if (j == 1) begin
                x_r[j] <= in_tdata[31:16];
              end else begin
                x_r[j] <= '0;
              end
            end
            tgt_r   <= in_tdata[47:32];
            train_r <= (in_tuser == mlpbp_pkg::ACT_TRAIN);
            pred_r  <= '0;
            err_r   <= '0;
            sat_r   <= 1'b0;
            j_r     <= '0;
            n_r     <= '0;
            acc_r   <= '0;
            oacc_r  <= '0;
            unique case (in_tuser)
              mlpbp_pkg::ACT_WRITE: state_r <= S_DONE;
              mlpbp_pkg::ACT_APPLY: state_r <= S_APPLY;
              default:              state_r <= S_FMUL;
            endcase
          end
        end
        S_APPLY: begin
          sat_r <= sat_r | ap_ovf;
          n_r   <= n_r + 1'b1;
          if (n_r == NW'(NH - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_FMUL: begin
          acc_r <= fmul_sum;
          j_r   <= j_r + 1'b1;
          if (j_r == JW'(NI - 1)) begin
            state_r <= S_FACT;
          end
        end
        S_FACT: begin
          sat_r   <= sat_r | h_ovf;
          state_r <= S_FDY;
        end
        S_FDY: begin
          y_r     <= rom_y;
          dy_r    <= dy_val;
          state_r <= S_FOUT;
        end
        S_FOUT: begin
          oacc_r <= oacc_sum;
          acc_r  <= '0;
          j_r    <= '0;
          n_r    <= n_r + 1'b1;
          if (n_r == NW'(NH - 1)) begin
            n_r     <= '0;
            state_r <= S_PRED;
          end else begin
            state_r <= S_FMUL;
          end
        end
        S_PRED: begin
          pred_r <= pred_v;
          if (train_r) begin
            err_r   <= err_v;
            sat_r   <= sat_r | pred_ovf | err_ovf;
            state_r <= S_BOY;
          end else begin
            sat_r   <= sat_r | pred_ovf;
            state_r <= S_DONE;
          end
        end
        S_BOY: begin
          t_r     <= 32'(err_r) * 32'($signed({1'b0, c_y[0]}));
          state_r <= S_BOC;
        end
        S_BOC: begin
          ocn_r   <= mlpbp_pkg::sat32(oc_sum);
          sat_r   <= sat_r | mlpbp_pkg::ovf32(oc_sum);
          state_r <= S_BEO;
        end
        S_BEO: begin
          t_r     <= 32'(err_r) * 32'($signed(c_ow[0]));
          state_r <= S_BHD;
        end
        S_BHD: begin
          hd_r    <= 20'(mlpbp_pkg::rnd_sh(64'(t_r) * 64'($signed({1'b0, c_dy[0]})), 24));
          j_r     <= '0;
          state_r <= S_BHM;
        end
        S_BHM: begin
          p_r     <= 36'(hd_r) * 36'(x_j);
          state_r <= S_BHA;
        end
        S_BHA: begin
          hcn_r[j_r*32 +: 32] <= mlpbp_pkg::sat32(hc_sum);
          sat_r <= sat_r | mlpbp_pkg::ovf32(hc_sum);
          if (j_r == JW'(NI - 1)) begin
            j_r <= '0;
            n_r <= n_r + 1'b1;
            if (n_r == NW'(NH - 1)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_BOY;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_BHM;
          end
        end
        S_DONE: begin
          // hand the word over once the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {err_r, pred_r};
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

`default_nettype wire

[sv/mlpbp_sigmoid_rom.sv]
// sigmoid lookup table, Q0.12 values, registered read
// depends on mlpbp_pkg (sig_value)
`default_nettype none

module mlpbp_sigmoid_rom #(
  parameter int ENTRIES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [$clog2(ENTRIES)-1:0] idx,
  output logic      [12:0]                y
);

  logic [12:0] tab [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_tab
    localparam logic [63:0] POS = (64'(2 * g + 1) << 35) / 64'(ENTRIES);
    localparam logic [12:0] VAL = mlpbp_pkg::sig_value(POS);
    assign tab[g] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= tab[idx];
    end
  end

endmodule

`default_nettype wire

[sv/mlpbp_cell.sv]
// one hidden neuron: its input weights, output weight, change accumulators and activations
// depends on mlpbp_pkg (wcmd_t); cells form a ring that rotates by one per shift
`default_nettype none

module mlpbp_cell #(
  parameter int NUM_INPUTS = 2,
  parameter int NUM_HIDDEN = 8,
  parameter int CELL_ID    = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       shift,
  input  wire mlpbp_pkg::wcmd_t           wr,
  input  wire logic [NUM_INPUTS*16-1:0]   hw_i,
  input  wire logic [15:0]                ow_i,
  input  wire logic [NUM_INPUTS*32-1:0]   hc_i,
  input  wire logic [31:0]                oc_i,
  input  wire logic [12:0]                y_i,
  input  wire logic [10:0]                dy_i,
  output logic      [NUM_INPUTS*16-1:0]   hw_o,
  output logic      [15:0]                ow_o,
  output logic      [NUM_INPUTS*32-1:0]   hc_o,
  output logic      [31:0]                oc_o,
  output logic      [12:0]                y_o,
  output logic      [10:0]                dy_o
);

  localparam int OW_IDX = NUM_INPUTS * NUM_HIDDEN + CELL_ID;

  logic [NUM_INPUTS*16-1:0] hw_r;
  logic [15:0]              ow_r;
  logic [NUM_INPUTS*32-1:0] hc_r;
  logic [31:0]              oc_r;
  logic [12:0]              y_r;
  logic [10:0]              dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
      ow_r <= '0;
      hc_r <= '0;
      oc_r <= '0;
    end else if (shift) begin
      hw_r <= hw_i;
      ow_r <= ow_i;
      hc_r <= hc_i;
      oc_r <= oc_i;
    end else if (wr.en) begin
      for (int j = 0; j < NUM_INPUTS; j++) begin
        if (32'(wr.idx) == 32'(CELL_ID * NUM_INPUTS + j)) begin
          hw_r[j*16 +: 16] <= wr.val;
        end
      end
      if (32'(wr.idx) == 32'(OW_IDX)) begin
        ow_r <= wr.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      y_r  <= y_i;
      dy_r <= dy_i;
    end
  end

  assign hw_o = hw_r;
  assign ow_o = ow_r;
  assign hc_o = hc_r;
  assign oc_o = oc_r;
  assign y_o  = y_r;
  assign dy_o = dy_r;

endmodule

`default_nettype wire

[dv/tb_mlp_backprop_trainer.sv]
// self-checking testbench of the two-layer perceptron trainer: random and directed words,
// each result checked against a behavioral predictor; depends on mlpbp_pkg and the rtl
`timescale 1ns / 1ps

module tb_mlp_backprop_trainer;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] fa;
    logic signed [15:0] fb;
    logic signed [15:0] tgt;
    logic [4:0]         widx;
    logic signed [15:0] wval;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pred;
    logic [15:0] err;
    logic        sat;
  } res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  mlp_backprop_trainer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0]    rate_q;
  longint         hw_q [16];
  longint         ow_q [8];
  longint         hc_q [16];
  longint         oc_q [8];
  int             sig_lut [256];
  bit             sat_seen;

  cmd_t  pending_words [$];
  res_t  expected_results [$];
  cmd_t  drv_word;
  int    fail_cnt;
  bit    quiet_mode;
  int    in_gap;
  int    out_gap;
  int    idle_cycles;

  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) begin
      sat_seen = 1;
      return hi;
    end
    if (v < lo) begin
      sat_seen = 1;
      return lo;
    end
    return v;
  endfunction

  task automatic build_lut();
    longint unsigned pos, mid, a, k, f, term, ef, inv, e, den, s;
    longint unsigned negk [9];
    bit neg;
    negk = '{64'd4294967296, 64'd1580030169, 64'd581260615, 64'd213833830, 64'd78665039,
             64'd28939263, 64'd10646160, 64'd3916503, 64'd1440801};
    for (int i = 0; i < 256; i++) begin
      pos = ((2 * longint'(i) + 1) << 35) / 256;
      mid = 64'd1 << 35;
      neg = pos < mid;
      a = neg ? mid - pos : pos - mid;
      k = a >> 32;
      f = a & 64'hffff_ffff;
      term = 64'd1 << 32;
      ef = term;
      for (int n = 1; n <= 20; n++) begin
        term = ((term * f) >> 32) / n;
        ef += term;
      end
      inv = 64'hffff_ffff_ffff_ffff / ef;
      if (k > 8) k = 8;
      e = (negk[k] * inv) >> 32;
      den = (64'd1 << 32) + e;
      s = ((64'd1 << 44) + den / 2) / den;
      sig_lut[i] = neg ? 4096 - int'(s) : int'(s);
    end
  endtask

  function automatic res_t predict_word(cmd_t c);
    res_t r;
    longint x [2], y [8], dy [8], acc, h, pred, err, hd;
    int idx;
    sat_seen = 0;
    pred = 0;
    err = 0;
    x[0] = c.fa;
    x[1] = c.fb;
    if (c.action == mlpbp_pkg::ACT_WRITE) begin
      if (c.widx < 16) hw_q[c.widx] = c.wval;
      else if (c.widx < 24) ow_q[c.widx - 16] = c.wval;
    end else if (c.action == mlpbp_pkg::ACT_APPLY) begin
      for (int i = 0; i < 16; i++) begin
        hw_q[i] = clamp(hw_q[i] + round_shift(hc_q[i], 12), -32768, 32767);
        hc_q[i] = 0;
      end
      for (int i = 0; i < 8; i++) begin
        ow_q[i] = clamp(ow_q[i] + round_shift(oc_q[i], 12), -32768, 32767);
        oc_q[i] = 0;
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        acc = hw_q[2*i] * x[0] + hw_q[2*i+1] * x[1];
        h = clamp(round_shift(acc, 12), -32768, 32767);
        idx = int'(((h + 32768) * 256) >>> 16);
        if (idx > 255) idx = 255;
        y[i] = sig_lut[idx];
        dy[i] = (y[i] * (4096 - y[i]) + 2048) >>> 12;
      end
      acc = 0;
      for (int i = 0; i < 8; i++) acc += ow_q[i] * y[i];
      pred = clamp(round_shift(acc, 12), -32768, 32767);
      if (c.action == mlpbp_pkg::ACT_TRAIN) begin
        err = clamp(longint'(c.tgt) - pred, -32768, 32767);
        for (int i = 0; i < 8; i++) begin
          hd = round_shift(err * ow_q[i] * dy[i], 24);
          oc_q[i] = clamp(oc_q[i] + round_shift(longint'(rate_q) * err * y[i], 16),
                          -64'sd2147483648, 64'sd2147483647);
          for (int j = 0; j < 2; j++)
            hc_q[2*i+j] = clamp(hc_q[2*i+j] + round_shift(longint'(rate_q) * hd * x[j], 16),
                                -64'sd2147483648, 64'sd2147483647);
        end
      end
    end
    r.pred = pred[15:0];
    r.err = err[15:0];
    r.sat = sat_seen;
    return r;
  endfunction

  function automatic cmd_t rand_word(logic [1:0] act, int mag);
    cmd_t c;
    c.action = act;
    c.fa = mag >= 16 ? 16'($urandom) : 16'($signed($urandom_range(0, 2*(1<<mag))) - (1<<mag));
    c.fb = mag >= 16 ? 16'($urandom) : 16'($signed($urandom_range(0, 2*(1<<mag))) - (1<<mag));
    c.tgt = 16'($urandom);
    c.widx = 5'($urandom);
    c.wval = mag >= 16 ? 16'($urandom) : 16'($signed($urandom_range(0, 2*(1<<mag))) - (1<<mag));
    return c;
  endfunction

  function automatic cmd_t make_word(logic [1:0] act, int fa, int fb, int tgt, int widx, int wval);
    cmd_t c;
    c.action = act;
    c.fa = 16'(fa);
    c.fb = 16'(fb);
    c.tgt = 16'(tgt);
    c.widx = 5'(widx);
    c.wval = 16'(wval);
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the word
    end else begin
      if (in_tvalid) expected_results.push_back(predict_word(drv_word));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 0;
      end else if (pending_words.size() > 0) begin
        cmd_t c;
        c = pending_words.pop_front();
        drv_word <= c;
        in_tvalid <= 1;
        in_tuser <= c.action;
        in_tdata <= {3'b0, c.wval, c.widx, c.tgt, c.fb, c.fa};
        if (!quiet_mode && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 10);
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // monitor and stall on the result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: actual %h/%b", $time, out_tdata, out_tuser);
          fail_cnt++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_tdata[15:0] !== e.pred) begin
            $display("%0t: prediction expected %h actual %h", $time, e.pred, out_tdata[15:0]);
            fail_cnt++;
          end
          if (out_tdata[31:16] !== e.err) begin
            $display("%0t: output_error expected %h actual %h", $time, e.err, out_tdata[31:16]);
            fail_cnt++;
          end
          if (out_tuser[0] !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, e.sat, out_tuser[0]);
            fail_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 9);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[mlp_backprop_trainer] ERROR");
      $finish;
    end
  end

  // sample after the edge so the driver's updates are settled
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_words.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_rate(logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    rate_q = v;
    cfg_valid <= 0;
  endtask

  task automatic load_weights(int mag);
    for (int i = 0; i < 24; i++) begin
      cmd_t c;
      c = rand_word(mlpbp_pkg::ACT_WRITE, mag);
      c.widx = 5'(i);
      pending_words.push_back(c);
    end
  endtask

  initial begin
    logic [15:0] rates [5];
    cmd_t c;
    int roll;
    rates = '{16'd6554, 16'd0, 16'hffff, 16'd300, 16'd40000};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_data = 0;
    fail_cnt = 0;
    quiet_mode = 0;
    rate_q = mlpbp_pkg::RATE_RESET;
    foreach (hw_q[i]) begin
      hw_q[i] = 0;
      hc_q[i] = 0;
    end
    foreach (ow_q[i]) begin
      ow_q[i] = 0;
      oc_q[i] = 0;
    end
    build_lut();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, all actions, ignored index, unused fields
    pending_words.push_back(make_word(mlpbp_pkg::ACT_INFER, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_WRITE, 0, 0, 0, 0, 32767));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_WRITE, 0, 0, 0, 1, -32768));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_WRITE, 0, 0, 0, 16, 32767));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_WRITE, 0, 0, 0, 17, -32768));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_WRITE, -1, -1, -1, 31, -1));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_WRITE, 0, 0, 0, 24, 1234));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_INFER, 32767, -32768, 5, 0, 0));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_INFER, -32768, 32767, 0, 0, 0));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_TRAIN, 32767, 32767, -32768, 0, 0));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_TRAIN, -32768, -32768, 32767, 0, 0));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_TRAIN, 4096, -4096, 4096, 0, 0));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_APPLY, 1, 2, 3, 4, 5));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_INFER, 4096, 4096, 0, 0, 0));
    pending_words.push_back(make_word(mlpbp_pkg::ACT_APPLY, 0, 0, 0, 0, 0));
    // sender pauses until every result is back
    wait_drained();

    foreach (rates[p]) begin
      write_rate(rates[p]);
      load_weights(p == 2 ? 16 : 13);
      for (int n = 0; n < 250; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 60)
          c = rand_word(mlpbp_pkg::ACT_TRAIN, $urandom_range(0, 3) == 0 ? 16 : 13);
        else if (roll < 80)
          c = rand_word(mlpbp_pkg::ACT_INFER, $urandom_range(0, 3) == 0 ? 16 : 13);
        else if (roll < 92)
          c = rand_word(mlpbp_pkg::ACT_APPLY, 13);
        else
          c = rand_word(mlpbp_pkg::ACT_WRITE, $urandom_range(0, 1) ? 16 : 12);
        pending_words.push_back(c);
      end
      if (p == 4) quiet_mode = 1;
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("[mlp_backprop_trainer] OK");
    end else begin
      $display("[mlp_backprop_trainer] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/mlpbp_pkg.sv
sv/mlpbp_sigmoid_rom.sv
sv/mlpbp_cell.sv
sv/mlp_backprop_trainer.sv
dv/tb_mlp_backprop_trainer.sv
